>>> src/fingerprint_packet_parser_top_macros.svh
// Assertion macros used by the packet parser port checker
`ifndef FINGERPRINT_PACKET_PARSER_TOP_MACROS_SVH
`define FINGERPRINT_PACKET_PARSER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define FPP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/fpp_pkg.sv
// Types and constants for the fingerprint packet parser
`default_nettype none

package fpp_pkg;

  localparam logic [7:0] HDR_BYTE0 = 8'hEF;
  localparam logic [7:0] HDR_BYTE1 = 8'h01;

  localparam logic [7:0] ID_CMD  = 8'd1;
  localparam logic [7:0] ID_DATA = 8'd2;
  localparam logic [7:0] ID_ACK  = 8'd7;
  localparam logic [7:0] ID_END  = 8'd8;

  localparam logic [2:0] KIND_UNKNOWN = 3'd0;
  localparam logic [2:0] KIND_COMMAND = 3'd1;
  localparam logic [2:0] KIND_DATA    = 3'd2;
  localparam logic [2:0] KIND_ACK     = 3'd3;
  localparam logic [2:0] KIND_END     = 3'd4;

  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_GOOD    = 2'd1;
  localparam logic [1:0] ST_CSUM    = 2'd2;
  localparam logic [1:0] ST_LEN_ERR = 2'd3;

  localparam logic [15:0] MIN_LENGTH = 16'd2;

  typedef enum logic [11:0] {
    PH_HUNT_EF = 12'b0000_0000_0001,
    PH_HUNT_01 = 12'b0000_0000_0010,
    PH_ADDR0   = 12'b0000_0000_0100,
    PH_ADDR1   = 12'b0000_0000_1000,
    PH_ADDR2   = 12'b0000_0001_0000,
    PH_ADDR3   = 12'b0000_0010_0000,
    PH_KIND    = 12'b0000_0100_0000,
    PH_LEN0    = 12'b0000_1000_0000,
    PH_LEN1    = 12'b0001_0000_0000,
    PH_DATA    = 12'b0010_0000_0000,
    PH_CS0     = 12'b0100_0000_0000,
    PH_CS1     = 12'b1000_0000_0000
  } phase_t;

endpackage

`default_nettype wire

>>> src/fingerprint_packet_parser_top.sv
// Fingerprint module serial packet parser, top level
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall | in_rx_byte
//  out_    | output    | out_valid/out_stall | status, payload, address, kind, length
//
//  One byte in per cycle unless in_stall is high; each byte gives one result
//  in the next cycle, from the result register loaded by the phase state machine.
//  Sync active-low reset returns to header hunt and clears all parse state.
//  in_stall rises only while a result is held and out_stall is high.
`default_nettype none

module fingerprint_packet_parser_top #(
  parameter int MAX_PACKET_LENGTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic             out_payload_valid,
  output logic [7:0]       out_payload_byte,
  output logic [7:0]       out_payload_index,
  output logic [31:0]      out_module_address,
  output logic [2:0]       out_packet_kind,
  output logic [15:0]      out_packet_length
);

  import fpp_pkg::*;

  localparam int CNT_W = $clog2(MAX_PACKET_LENGTH);
  localparam logic [15:0] MAX_LEN = 16'(MAX_PACKET_LENGTH);

  phase_t             phase_r, phase_nxt;
  logic [31:0]        address_r, address_nxt;
  logic [2:0]         kind_r, kind_nxt;
  logic [15:0]        length_r, length_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [15:0]        sum_r, sum_nxt;
  logic [7:0]         csum_hi_r, csum_hi_nxt;

  logic               out_valid_r;
  logic [1:0]         status_r, status_nxt;
  logic               pvalid_r, pvalid_nxt;
  logic [7:0]         pbyte_r, pbyte_nxt;
  logic [7:0]         pindex_r, pindex_nxt;

  logic               accept;
  logic [15:0]        len_full;
  logic [15:0]        count_ext;
  logic [16:0]        count_end;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign len_full  = {length_r[15:8], in_rx_byte};
  assign count_ext = 16'(count_r);
  assign count_end = 17'(count_ext) + 17'd3;

  always_comb begin
    phase_nxt   = phase_r;
    address_nxt = address_r;
    kind_nxt    = kind_r;
    length_nxt  = length_r;
    count_nxt   = count_r;
    sum_nxt     = sum_r;
    csum_hi_nxt = csum_hi_r;
    status_nxt  = ST_NONE;
    pvalid_nxt  = 1'b0;
    pbyte_nxt   = 8'd0;
    pindex_nxt  = 8'd0;
    unique case (phase_r)
      PH_HUNT_EF: begin
        if (in_rx_byte == HDR_BYTE0) phase_nxt = PH_HUNT_01;
      end
      PH_HUNT_01: begin
        phase_nxt = (in_rx_byte == HDR_BYTE1) ? PH_ADDR0 : PH_HUNT_EF;
      end
      PH_ADDR0: begin
        address_nxt = {in_rx_byte, 24'd0};
        phase_nxt   = PH_ADDR1;
      end
      PH_ADDR1: begin
        address_nxt[23:16] = in_rx_byte;
        phase_nxt          = PH_ADDR2;
      end
      PH_ADDR2: begin
        address_nxt[15:8] = in_rx_byte;
        phase_nxt         = PH_ADDR3;
      end
      PH_ADDR3: begin
        address_nxt[7:0] = in_rx_byte;
        phase_nxt        = PH_KIND;
      end
      PH_KIND: begin
        sum_nxt = 16'(in_rx_byte);
        case (in_rx_byte)
          ID_CMD:  kind_nxt = KIND_COMMAND;
          ID_DATA: kind_nxt = KIND_DATA;
          ID_ACK:  kind_nxt = KIND_ACK;
          ID_END:  kind_nxt = KIND_END;
          default: kind_nxt = KIND_UNKNOWN;
        endcase
        phase_nxt = PH_LEN0;
      end
      PH_LEN0: begin
        sum_nxt    = sum_r + 16'(in_rx_byte);
        length_nxt = {in_rx_byte, 8'd0};
        phase_nxt  = PH_LEN1;
      end
      PH_LEN1: begin
        sum_nxt    = sum_r + 16'(in_rx_byte);
        length_nxt = len_full;
        if (len_full > MAX_LEN || len_full < MIN_LENGTH) begin
          status_nxt = ST_LEN_ERR;
          phase_nxt  = PH_HUNT_EF;
        end else if (len_full == MIN_LENGTH) begin
          phase_nxt = PH_CS0;
        end else begin
          count_nxt = '0;
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        sum_nxt    = sum_r + 16'(in_rx_byte);
        pvalid_nxt = 1'b1;
        pbyte_nxt  = in_rx_byte;
        pindex_nxt = count_ext[7:0];
        count_nxt  = count_r + 1'b1;
        if (count_end >= 17'(length_r)) phase_nxt = PH_CS0;
      end
      PH_CS0: begin
        csum_hi_nxt = in_rx_byte;
        phase_nxt   = PH_CS1;
      end
      PH_CS1: begin
        status_nxt = ({csum_hi_r, in_rx_byte} == sum_r) ? ST_GOOD : ST_CSUM;
        phase_nxt  = PH_HUNT_EF;
      end
      default: begin
        phase_nxt = PH_HUNT_EF;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT_EF;
      address_r   <= '0;
      kind_r      <= '0;
      length_r    <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      csum_hi_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept | in_stall;
      if (accept) begin
        phase_r   <= phase_nxt;
        address_r <= address_nxt;
        kind_r    <= kind_nxt;
        length_r  <= length_nxt;
        count_r   <= count_nxt;
        sum_r     <= sum_nxt;
        csum_hi_r <= csum_hi_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      pvalid_r <= pvalid_nxt;
      pbyte_r  <= pbyte_nxt;
      pindex_r <= pindex_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_payload_valid  = pvalid_r;
  assign out_payload_byte   = pbyte_r;
  assign out_payload_index  = pindex_r;
  assign out_module_address = address_r;
  assign out_packet_kind    = kind_r;
  assign out_packet_length  = length_r;

endmodule

`default_nettype wire

>>> src/fpp_checker.sv
// Port-level checker for the packet parser and its bind
`default_nettype none

`include "fingerprint_packet_parser_top_macros.svh"

module fpp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_status,
  input wire logic        out_payload_valid,
  input wire logic [7:0]  out_payload_byte,
  input wire logic [7:0]  out_payload_index,
  input wire logic [15:0] out_packet_length
);

  import fpp_pkg::*;

  `FPP_ASSERT_NOW(a_stall_only_when_full, !(out_valid && out_stall), !in_stall,
    "input stalled while result register free")
  `FPP_ASSERT_NOW(a_payload_no_status, out_valid && out_payload_valid,
    out_status == ST_NONE && out_packet_length > 16'd2,
    "payload transfer with status or short length")
  `FPP_ASSERT_NOW(a_idle_payload_zero, out_valid && !out_payload_valid,
    out_payload_byte == 8'd0 && out_payload_index == 8'd0,
    "payload fields set on non-payload transfer")
  `FPP_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_status) && $stable(out_payload_byte),
    "stalled result changed")

endmodule

bind fingerprint_packet_parser_top fpp_checker u_fpp_checker (.*);

`default_nettype wire

>>> test/packet_parse_checker.sv
// Checker for the packet parser: predicts each result from the accepted bytes and compares
module packet_parse_checker #(
  parameter int MAX_PACKET_LENGTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic        out_payload_valid,
  input  logic [7:0]  out_payload_byte,
  input  logic [7:0]  out_payload_index,
  input  logic [31:0] out_module_address,
  input  logic [2:0]  out_packet_kind,
  input  logic [15:0] out_packet_length,
  output int          mismatch_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import fpp_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic        pvalid;
    logic [7:0]  pbyte;
    logic [7:0]  pindex;
    logic [31:0] addr;
    logic [2:0]  kind;
    logic [15:0] length;
  } parse_result_t;

  phase_t        parse_phase;
  logic [31:0]   addr_q;
  logic [2:0]    kind_q;
  logic [15:0]   length_q;
  logic [15:0]   payload_count_q;
  logic [15:0]   sum_q;
  logic [7:0]    csum_high_q;
  parse_result_t parse_results_due[$];
  parse_result_t want;

  initial begin
    mismatch_count = 0;
    pending = 0;
  end

  function automatic parse_result_t parse_byte(input logic [7:0] b);
    parse_result_t r;
    r = '0;
    if (parse_phase == PH_KIND) begin
      sum_q = 16'(b);
    end else if (parse_phase == PH_LEN0 || parse_phase == PH_LEN1 || parse_phase == PH_DATA) begin
      sum_q = sum_q + 16'(b);
    end
    case (parse_phase)
      PH_HUNT_EF: begin
        if (b == HDR_BYTE0) parse_phase = PH_HUNT_01;
      end
      PH_HUNT_01: begin
        parse_phase = (b == HDR_BYTE1) ? PH_ADDR0 : PH_HUNT_EF;
      end
      PH_ADDR0: begin
        addr_q = {b, 24'h0};
        parse_phase = PH_ADDR1;
      end
      PH_ADDR1: begin
        addr_q = addr_q | {8'h0, b, 16'h0};
        parse_phase = PH_ADDR2;
      end
      PH_ADDR2: begin
        addr_q = addr_q | {16'h0, b, 8'h0};
        parse_phase = PH_ADDR3;
      end
      PH_ADDR3: begin
        addr_q = addr_q | {24'h0, b};
        parse_phase = PH_KIND;
      end
      PH_KIND: begin
        case (b)
          ID_CMD:  kind_q = KIND_COMMAND;
          ID_DATA: kind_q = KIND_DATA;
          ID_ACK:  kind_q = KIND_ACK;
          ID_END:  kind_q = KIND_END;
          default: kind_q = KIND_UNKNOWN;
        endcase
        parse_phase = PH_LEN0;
      end
      PH_LEN0: begin
        length_q = {b, 8'h00};
        parse_phase = PH_LEN1;
      end
      PH_LEN1: begin
        length_q = {length_q[15:8], b};
        if (int'(length_q) > MAX_PACKET_LENGTH || length_q < MIN_LENGTH) begin
          r.status = ST_LEN_ERR;
          parse_phase = PH_HUNT_EF;
        end else if (length_q == MIN_LENGTH) begin
          parse_phase = PH_CS0;
        end else begin
          payload_count_q = '0;
          parse_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        r.pvalid = 1'b1;
        r.pbyte = b;
        r.pindex = payload_count_q[7:0];
        payload_count_q = payload_count_q + 16'd1;
        if (32'(payload_count_q) + 32'd2 >= 32'(length_q)) parse_phase = PH_CS0;
      end
      PH_CS0: begin
        csum_high_q = b;
        parse_phase = PH_CS1;
      end
      PH_CS1: begin
        r.status = ({csum_high_q, b} == sum_q) ? ST_GOOD : ST_CSUM;
        parse_phase = PH_HUNT_EF;
      end
      default: begin
        parse_phase = PH_HUNT_EF;
      end
    endcase
    r.addr = addr_q;
    r.kind = kind_q;
    r.length = length_q;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("mismatch at %0t: %s got %0h, expected %0h", $realtime, field, got, exp_val);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      parse_phase = PH_HUNT_EF;
      addr_q = '0;
      kind_q = KIND_UNKNOWN;
      length_q = '0;
      payload_count_q = '0;
      sum_q = '0;
      csum_high_q = '0;
      parse_results_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (parse_results_due.size() == 0) begin
          report_mismatch("result with none due, status", 32'(out_status), '0);
        end else begin
          want = parse_results_due.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", 32'(out_status), 32'(want.status));
          if (out_payload_valid !== want.pvalid)
            report_mismatch("payload_valid", 32'(out_payload_valid), 32'(want.pvalid));
          if (out_payload_byte !== want.pbyte)
            report_mismatch("payload_byte", 32'(out_payload_byte), 32'(want.pbyte));
          if (out_payload_index !== want.pindex)
            report_mismatch("payload_index", 32'(out_payload_index), 32'(want.pindex));
          if (out_module_address !== want.addr)
            report_mismatch("module_address", out_module_address, want.addr);
          if (out_packet_kind !== want.kind)
            report_mismatch("packet_kind", 32'(out_packet_kind), 32'(want.kind));
          if (out_packet_length !== want.length)
            report_mismatch("packet_length", 32'(out_packet_length), 32'(want.length));
        end
      end
      if (in_valid && !in_stall) begin
        parse_results_due.push_back(parse_byte(in_rx_byte));
      end
    end
    pending <= parse_results_due.size();
  end

endmodule

>>> test/testbench.sv
// Testbench top for the packet parser: clock, reset, byte stimulus and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fpp_pkg::*;

  localparam int MAX_LEN = 256;
  localparam int BYTE_TARGET = 1950;
  localparam int QUIET_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic        out_payload_valid;
  logic [7:0]  out_payload_byte;
  logic [7:0]  out_payload_index;
  logic [31:0] out_module_address;
  logic [2:0]  out_packet_kind;
  logic [15:0] out_packet_length;

  int mismatch_count;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int bytes_sent = 0;
  int quiet_cycles = 0;

  fingerprint_packet_parser_top #(
    .MAX_PACKET_LENGTH(MAX_LEN)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_payload_valid  (out_payload_valid),
    .out_payload_byte   (out_payload_byte),
    .out_payload_index  (out_payload_index),
    .out_module_address (out_module_address),
    .out_packet_kind    (out_packet_kind),
    .out_packet_length  (out_packet_length)
  );

  packet_parse_checker #(
    .MAX_PACKET_LENGTH(MAX_LEN)
  ) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_payload_valid  (out_payload_valid),
    .out_payload_byte   (out_payload_byte),
    .out_payload_index  (out_payload_index),
    .out_module_address (out_module_address),
    .out_packet_kind    (out_packet_kind),
    .out_packet_length  (out_packet_length),
    .mismatch_count     (mismatch_count),
    .pending            (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** fingerprint_packet_parser_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    bytes_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_packet(input logic [31:0] addr, input logic [7:0] pid,
                             input logic [15:0] len, input bit bad_csum);
    logic [15:0] sum;
    logic [7:0]  data;
    sum = 16'(pid) + 16'(len[15:8]) + 16'(len[7:0]);
    send_byte(HDR_BYTE0);
    send_byte(HDR_BYTE1);
    send_byte(addr[31:24]);
    send_byte(addr[23:16]);
    send_byte(addr[15:8]);
    send_byte(addr[7:0]);
    send_byte(pid);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    if (len < MIN_LENGTH || int'(len) > MAX_LEN) return;
    for (int i = 0; i < int'(len) - 2; i++) begin
      data = 8'($urandom);
      sum = sum + 16'(data);
      send_byte(data);
    end
    if (bad_csum) sum = sum ^ 16'($urandom_range(65535, 1));
    send_byte(sum[15:8]);
    send_byte(sum[7:0]);
  endtask

  // drop valid and hold until every predicted result has been taken
  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    logic [31:0] addr;
    logic [7:0]  pid;
    logic [15:0] len;
    int          sel;
    int          target;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // second header byte wrong, then a bare 01 that must be ignored
    send_byte(HDR_BYTE0);
    send_byte(HDR_BYTE0);
    send_byte(HDR_BYTE1);
    send_packet(32'hFFFF_FFFF, ID_END, MIN_LENGTH, 1'b0);
    send_packet(32'h0000_0000, ID_ACK, 16'd1, 1'b0);
    drain();

    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 76; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      target = BYTE_TARGET * (mode + 1) / 4;
      while (bytes_sent < target) begin
        sel = $urandom_range(99);
        case ($urandom_range(9))
          0: addr = 32'h0000_0000;
          1: addr = 32'hFFFF_FFFF;
          default: addr = $urandom;
        endcase
        case ($urandom_range(5))
          0: pid = ID_CMD;
          1: pid = ID_DATA;
          2: pid = ID_ACK;
          3: pid = ID_END;
          default: pid = 8'($urandom);
        endcase
        if (sel < 85) begin
          if ($urandom_range(39) == 0) len = 16'($urandom_range(MAX_LEN, 200));
          else len = 16'($urandom_range(24, 2));
          send_packet(addr, pid, len, $urandom_range(4) == 0);
        end else if (sel < 93) begin
          case ($urandom_range(3))
            0: len = 16'($urandom_range(1, 0));
            1: len = 16'(MAX_LEN + 1);
            2: len = 16'($urandom_range(65535, MAX_LEN + 1));
            default: len = 16'hFFFF;
          endcase
          send_packet(addr, pid, len, 1'b0);
        end else begin
          repeat ($urandom_range(6, 1)) begin
            send_byte(($urandom_range(3) == 0) ? HDR_BYTE0 : 8'($urandom));
          end
        end
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** fingerprint_packet_parser_top: PASSED **");
    end else begin
      $display("** fingerprint_packet_parser_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/fpp_pkg.sv
src/fingerprint_packet_parser_top.sv
src/fpp_checker.sv
test/packet_parse_checker.sv
test/testbench.sv
